@@ rtl/core/cda_pkg.sv @@
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, unit codes and calendar helpers for the date adder core.
// ----------------------------------------------------------------------------
package cda_pkg;

    localparam logic [2:0] KIND_DAYS    = 3'd0;
    localparam logic [2:0] KIND_WEEKS   = 3'd1;
    localparam logic [2:0] KIND_MONTHS  = 3'd2;
    localparam logic [2:0] KIND_YEARS   = 3'd3;
    localparam logic [2:0] KIND_DECADES = 3'd4;

    localparam int MONTHS_PER_YEAR = 12;
    localparam int YEAR_CYCLE      = 400;
    localparam int CENTURY         = 100;
    localparam int DIV_STEPS       = 2;

    // Reciprocals for the constant divider: q = (x * RECIP) >> SHIFT,
    // exact for a 15-bit year over 400 and an 11-bit month index over 12
    localparam int YEAR_RECIP  = 41944;
    localparam int YEAR_SHIFT  = 24;
    localparam int MONTH_RECIP = 2731;
    localparam int MONTH_SHIFT = 15;

    localparam logic [3:0] MONTH_FEB  = 4'd2;
    localparam logic [3:0] MONTH_DEC  = 4'd12;
    localparam logic [4:0] DAY_LEAP   = 5'd29;
    localparam logic [4:0] DAY_COMMON = 5'd28;

    localparam logic [4:0] MONTH_LEN [MONTHS_PER_YEAR] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;         // capture an input beat, start year / 400
        logic div_step;     // one stage of the reciprocal divider
        logic div_idx;      // start month index / 12
        logic check;        // validate the start date, set up day count
        logic day_step;     // advance by one month-sized jump or finish
        logic month_apply;  // fold quotient into the year, month from remainder, start year / 400
        logic clamp;        // clamp day to the length of the final month
        logic year_apply;   // add years or decades, move Feb 29 to Feb 28
        logic out_load;     // move the result into the output register
    } cda_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic       bad_now;
        logic [2:0] kind;
        logic       days_zero;
    } cda_status_t;

    // Leap year from the year's remainder modulo 400
    function automatic logic is_leap(input logic [8:0] r400);
        logic cent;
        cent = (r400 == 9'(CENTURY)) || (r400 == 9'(2 * CENTURY)) ||
               (r400 == 9'(3 * CENTURY));
        return (r400[1:0] == 2'b00) && !cent;
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        if (m == 4'd0 || m > 4'(MONTHS_PER_YEAR)) begin
            len = 5'd0;
        end else if (m == MONTH_FEB) begin
            len = leap ? DAY_LEAP : DAY_COMMON;
        end else begin
            len = MONTH_LEN[m - 4'd1];
        end
        return len;
    endfunction

endpackage

@@ rtl/core/cda_datapath.sv @@
// ----------------------------------------------------------------------------
// cda_datapath
// Date registers, constant divider (by 400 or 12) and the date step logic.
// ----------------------------------------------------------------------------
module cda_datapath
    import cda_pkg::*;
(
    input  logic        aclk,
    input  cda_cmd_t    cmd,
    output cda_status_t status,
    input  logic [2:0]  in_kind,
    input  logic [4:0]  in_day,
    input  logic [3:0]  in_month,
    input  logic [13:0] in_year,
    input  logic [9:0]  in_amount,
    output logic [4:0]  out_day,
    output logic [3:0]  out_month,
    output logic [14:0] out_year,
    output logic        out_bad
);

    logic [2:0]  kind_reg;
    logic [4:0]  d_reg;
    logic [3:0]  m_reg;
    logic [14:0] y_reg;
    logic [9:0]  n_reg;
    logic        bad_reg;
    logic [12:0] rem_reg;
    logic [14:0] dq_reg;
    logic [6:0]  qt_reg;
    logic [8:0]  dr_reg;
    logic        sel12_reg;

    logic [4:0]  out_day_reg;
    logic [3:0]  out_month_reg;
    logic [14:0] out_year_reg;
    logic        out_bad_reg;

    logic [4:0]  len;
    logic        bad_now;
    logic [9:0]  divisor;
    logic [30:0] y_prod;
    logic [22:0] m_prod;
    logic [6:0]  quot;
    logic [14:0] div_prod;
    logic [14:0] div_rem;
    logic [4:0]  gap;
    logic [14:0] y_month;
    logic [13:0] year_add;
    logic [12:0] weeks_days;
    logic [10:0] month_idx;

    // dr_reg holds the year mod 400 in the check, day and clamp steps
    assign len     = days_in(m_reg, is_leap(dr_reg));
    assign bad_now = (len == 5'd0) || (d_reg == 5'd0) || (d_reg > len);

    // Stage one: quotient by reciprocal multiply; stage two: remainder
    assign divisor  = sel12_reg ? 10'(MONTHS_PER_YEAR) : 10'(YEAR_CYCLE);
    assign y_prod   = {16'd0, dq_reg} * 31'(YEAR_RECIP);
    assign m_prod   = {12'd0, dq_reg[10:0]} * 23'(MONTH_RECIP);
    assign quot     = sel12_reg ? m_prod[MONTH_SHIFT +: 7] : y_prod[YEAR_SHIFT +: 7];
    assign div_prod = {8'd0, qt_reg} * {5'd0, divisor};
    assign div_rem  = dq_reg - div_prod;

    assign gap        = len - d_reg;
    assign y_month    = y_reg + {8'd0, qt_reg};
    assign year_add   = (kind_reg == KIND_DECADES) ?
                        ({1'b0, n_reg, 3'b000} + {3'b000, n_reg, 1'b0}) : {4'd0, n_reg};
    assign weeks_days = {n_reg, 3'b000} - {3'b000, n_reg};
    assign month_idx  = {7'd0, m_reg - 4'd1} + {1'b0, n_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= in_kind;
            d_reg     <= in_day;
            m_reg     <= in_month;
            y_reg     <= {1'b0, in_year};
            n_reg     <= in_amount;
            dq_reg    <= {1'b0, in_year};
            dr_reg    <= 9'd0;
            sel12_reg <= 1'b0;
        end
        if (cmd.div_step) begin
            qt_reg <= quot;
            dr_reg <= div_rem[8:0];
        end
        if (cmd.check) begin
            bad_reg <= bad_now;
            rem_reg <= (kind_reg == KIND_WEEKS) ? weeks_days : {3'd0, n_reg};
        end
        if (cmd.div_idx) begin
            dq_reg    <= {4'd0, month_idx};
            dr_reg    <= 9'd0;
            sel12_reg <= 1'b1;
        end
        if (cmd.day_step) begin
            if (rem_reg <= {8'd0, gap}) begin
                d_reg   <= d_reg + rem_reg[4:0];
                rem_reg <= 13'd0;
            end else begin
                rem_reg <= rem_reg - {8'd0, gap} - 13'd1;
                d_reg   <= 5'd1;
                if (m_reg == MONTH_DEC) begin
                    m_reg  <= 4'd1;
                    y_reg  <= y_reg + 15'd1;
                    dr_reg <= (dr_reg == 9'(YEAR_CYCLE - 1)) ? 9'd0 : dr_reg + 9'd1;
                end else begin
                    m_reg <= m_reg + 4'd1;
                end
            end
        end
        if (cmd.month_apply) begin
            y_reg     <= y_month;
            m_reg     <= dr_reg[3:0] + 4'd1;
            dq_reg    <= y_month;
            dr_reg    <= 9'd0;
            sel12_reg <= 1'b0;
        end
        if (cmd.clamp) begin
            if (d_reg > len) begin
                d_reg <= len;
            end
        end
        if (cmd.year_apply) begin
            y_reg <= y_reg + {1'b0, year_add};
            if (n_reg != 10'd0 && m_reg == MONTH_FEB && d_reg == DAY_LEAP) begin
                d_reg <= DAY_COMMON;
            end
        end
        if (cmd.out_load) begin
            out_day_reg   <= d_reg;
            out_month_reg <= m_reg;
            out_year_reg  <= y_reg;
            out_bad_reg   <= bad_reg;
        end
    end

    assign status.bad_now   = bad_now;
    assign status.kind      = kind_reg;
    assign status.days_zero = (rem_reg == 13'd0);

    assign out_day   = out_day_reg;
    assign out_month = out_month_reg;
    assign out_year  = out_year_reg;
    assign out_bad   = out_bad_reg;

endmodule

@@ rtl/core/cda_ctrl.sv @@
// ----------------------------------------------------------------------------
// cda_ctrl
// Sequencer for one request at a time: divide, check, step, deliver.
// ----------------------------------------------------------------------------
module cda_ctrl
    import cda_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  cda_status_t status,
    output cda_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_Y1,
        ST_CHECK,
        ST_DAYS,
        ST_DIV_M,
        ST_MAPPLY,
        ST_DIV_Y2,
        ST_CLAMP,
        ST_YEARS,
        ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       m_valid_reg, m_valid_next;
    logic       div_last;

    assign div_last = (cnt_reg == 4'(DIV_STEPS - 1));

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = 4'd0;
                    state_next = ST_DIV_Y1;
                end
            end
            ST_DIV_Y1, ST_DIV_M, ST_DIV_Y2: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 4'd1;
                if (div_last) begin
                    cnt_next = 4'd0;
                    case (state_reg)
                        ST_DIV_Y1: state_next = ST_CHECK;
                        ST_DIV_M:  state_next = ST_MAPPLY;
                        default:   state_next = ST_CLAMP;
                    endcase
                end
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                if (status.bad_now) begin
                    state_next = ST_OUT;
                end else begin
                    case (status.kind)
                        KIND_DAYS, KIND_WEEKS: state_next = ST_DAYS;
                        KIND_MONTHS: begin
                            cmd.div_idx = 1'b1;
                            state_next  = ST_DIV_M;
                        end
                        KIND_YEARS, KIND_DECADES: state_next = ST_YEARS;
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_DAYS: begin
                if (status.days_zero) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.day_step = 1'b1;
                end
            end
            ST_MAPPLY: begin
                cmd.month_apply = 1'b1;
                state_next      = ST_DIV_Y2;
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_OUT;
            end
            ST_YEARS: begin
                cmd.year_apply = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

@@ rtl/core/calendar_date_adder_core.sv @@
// ----------------------------------------------------------------------------
// calendar_date_adder_core
// Adds days, weeks, months, years or decades to a Gregorian date.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one beat per request, the start date and amount in
//   s_tdata, the unit code in s_tuser. Master channel: one beat per request,
//   the advanced date in m_tdata, the invalid-date flag in m_tuser. An
//   invalid start date comes back unchanged with the flag set.
//   One request is in flight at a time; s_tready is high only while idle.
//   The result passes through a two-stage reciprocal divider and, for days
//   and weeks, a month-jump loop that steps one month boundary at a time.
//   The next request is taken at the earliest at the edge where the result
//   can first be taken.
//   A stalled receiver holds the result in the output register; a finished
//   next result waits until that register is taken.
//   Reset (aresetn low, synchronous) returns to idle and drops m_tvalid.
// ----------------------------------------------------------------------------
module calendar_date_adder_core
    import cda_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // day[4:0] month[8:5] year[22:9] amount[32:23], zero pad
    input  logic [2:0]  s_tuser,  // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // new_day[4:0] new_month[8:5] new_year[23:9]
    output logic        m_tuser   // bad_date[0]
);

    cda_cmd_t    cmd;
    cda_status_t status;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [14:0] out_year;

    cda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cda_datapath u_dp (
        .aclk      (aclk),
        .cmd       (cmd),
        .status    (status),
        .in_kind   (s_tuser),
        .in_day    (s_tdata[4:0]),
        .in_month  (s_tdata[8:5]),
        .in_year   (s_tdata[22:9]),
        .in_amount (s_tdata[32:23]),
        .out_day   (out_day),
        .out_month (out_month),
        .out_year  (out_year),
        .out_bad   (m_tuser)
    );

    assign m_tdata = {out_year, out_month, out_day};

endmodule

@@ rtl/core/cda_checker.sv @@
// ----------------------------------------------------------------------------
// cda_checker
// Port-level checks for the date adder core, bound to the top level.
// ----------------------------------------------------------------------------
module cda_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // One request at a time: an accepted beat closes the input
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a request was in flight");

    // A result for a valid start date is itself a valid-looking date
    a_result_date: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[4:0] != 5'd0) &&
                                 (m_tdata[8:5] != 4'd0) && (m_tdata[8:5] <= 4'd12))
        else $error("result date out of range");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind calendar_date_adder_core cda_checker u_cda_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
